// ===== rtl/core/dbbsd_pkg.sv =====
// Shared types and constants for the dial and button box stream decoder.
`timescale 1ns / 1ps

package dbbsd_pkg;

    localparam int DIAL_COUNT = 8;
    localparam int DIAL_IW    = 3;
    localparam int RANGE_W    = 14;
    localparam int MID_W      = 18;
    localparam int POS_W      = 16;
    localparam int OFF_W      = 15;
    localparam int DELTA_W    = 17;
    localparam int BTN_IW     = 5;
    localparam int BTN_COUNT  = 32;
    localparam int OUT_DATA_W = 80;

    localparam logic [RANGE_W-1:0] HALF_RANGE_RESET = 14'd200;

    localparam logic [7:0] BTN_CODE_FIRST  = 8'hC0;
    localparam logic [4:0] DIAL_START_HIGH = 5'b00110;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_DIAL   = 2'd2,
        EV_RESYNC = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        PH_CMD  = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } parse_phase_t;

    // Control from the parser to the per-dial state bank.
    typedef struct packed {
        logic               commit;
        logic               clear;
        logic [DIAL_IW-1:0] index;
    } dial_cmd_t;

    // Control from the parser to the button tracker.
    typedef struct packed {
        logic commit;
        logic hit;
        logic clear;
    } btn_cmd_t;

endpackage

// ===== rtl/core/dbbsd_button.sv =====
// Button code decode and pressed-vector register.
`timescale 1ns / 1ps

module dbbsd_button (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dbbsd_pkg::btn_cmd_t               cmd,
    input  logic [7:0]                        code,
    output logic [dbbsd_pkg::BTN_IW-1:0]      index,
    output logic                              pressed,
    output logic [dbbsd_pkg::BTN_COUNT-1:0]   vector_next
);

    logic [dbbsd_pkg::BTN_COUNT-1:0] vector_reg;

    // Banks of eight run from button 24 down to button 0.
    assign index   = {~code[4:3], code[2:0]};
    assign pressed = ~code[5];

    always_comb begin
        vector_next = vector_reg;
        if (cmd.clear) begin
            vector_next = '0;
        end else if (cmd.hit) begin
            vector_next[index] = pressed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_reg <= '0;
        end else if (cmd.commit) begin
            vector_reg <= vector_next;
        end
    end

endmodule

// ===== rtl/core/dbbsd_dial.sv =====
// Per-dial window midpoint and previous position, with offset and delta math.
`timescale 1ns / 1ps

module dbbsd_dial (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  dbbsd_pkg::dial_cmd_t                    cmd,
    input  logic signed [dbbsd_pkg::POS_W-1:0]      position,
    input  logic [dbbsd_pkg::RANGE_W-1:0]           half_range,
    output logic signed [dbbsd_pkg::OFF_W-1:0]      offset,
    output logic                                    saturated,
    output logic signed [dbbsd_pkg::DELTA_W-1:0]    delta
);

    logic signed [dbbsd_pkg::MID_W-1:0] mid_reg  [dbbsd_pkg::DIAL_COUNT];
    logic signed [dbbsd_pkg::POS_W-1:0] prev_reg [dbbsd_pkg::DIAL_COUNT];

    logic signed [dbbsd_pkg::MID_W-1:0] pos_ext;
    logic signed [dbbsd_pkg::MID_W-1:0] range_pos;
    logic signed [dbbsd_pkg::MID_W-1:0] range_neg;
    logic signed [dbbsd_pkg::MID_W-1:0] temp;
    logic signed [dbbsd_pkg::MID_W-1:0] mid_next;

    assign pos_ext   = dbbsd_pkg::MID_W'(position);
    assign range_pos = signed'({{(dbbsd_pkg::MID_W - dbbsd_pkg::RANGE_W){1'b0}}, half_range});
    assign range_neg = -range_pos;
    assign temp      = pos_ext - mid_reg[cmd.index];

    always_comb begin
        offset    = temp[dbbsd_pkg::OFF_W-1:0];
        saturated = 1'b0;
        mid_next  = mid_reg[cmd.index];
        if (temp > range_pos) begin
            // clamp high and drag the window up
            offset    = range_pos[dbbsd_pkg::OFF_W-1:0];
            saturated = 1'b1;
            mid_next  = pos_ext - range_pos;
        end else if (temp < range_neg) begin
            offset    = range_neg[dbbsd_pkg::OFF_W-1:0];
            saturated = 1'b1;
            mid_next  = pos_ext + range_pos;
        end
    end

    assign delta = dbbsd_pkg::DELTA_W'(position) - dbbsd_pkg::DELTA_W'(prev_reg[cmd.index]);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int d = 0; d < dbbsd_pkg::DIAL_COUNT; d++) begin
                mid_reg[d]  <= '0;
                prev_reg[d] <= '0;
            end
        end else if (cmd.commit) begin
            mid_reg[cmd.index]  <= mid_next;
            prev_reg[cmd.index] <= position;
        end
    end

endmodule

// ===== rtl/core/dial_button_box_stream_decoder_unit.sv =====
// Top level: byte parser, input and result registers, button and dial units.
// A byte accepted into the input register is parsed from there into the result register.
// Throughput: one byte per cycle while unstalled; a dial update is one add, compare and select.
// While a result waits on m_tready, one more byte fits in the input register, then s_tready drops.
// Reset (aresetn low, synchronous): parser to command phase, buttons released,
// all dial midpoints and positions zero, half range back to 200, both registers empty.
`timescale 1ns / 1ps

module dial_button_box_stream_decoder_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [dbbsd_pkg::RANGE_W-1:0]         cfg_wdata,   // dial_half_range
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,     // rx_byte
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // button_index[4:0], button_pressed[5], button_vector[37:6], dial_index[40:38],
    // dial_offset[55:41], dial_saturated[56], dial_delta[73:57], zero[79:74]
    output logic [dbbsd_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                            m_tuser      // event_kind
);

    logic [dbbsd_pkg::RANGE_W-1:0] half_range_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    dbbsd_pkg::parse_phase_t           phase_reg, phase_next;
    logic [dbbsd_pkg::DIAL_IW-1:0]     pend_dial_reg, pend_dial_next;
    logic [7:0]                        pend_high_reg, pend_high_next;

    logic is_button;
    logic is_start;
    logic resync;

    dbbsd_pkg::btn_cmd_t  btn_cmd;
    dbbsd_pkg::dial_cmd_t dial_cmd;

    logic [dbbsd_pkg::BTN_IW-1:0]             btn_index;
    logic                                     btn_pressed;
    logic [dbbsd_pkg::BTN_COUNT-1:0]          btn_vector;
    logic signed [dbbsd_pkg::OFF_W-1:0]       dial_offset;
    logic                                     dial_sat;
    logic signed [dbbsd_pkg::DELTA_W-1:0]     dial_delta;

    dbbsd_pkg::event_kind_t                   kind_next;
    logic [dbbsd_pkg::OUT_DATA_W-1:0]         data_next;

    logic                                     out_valid_reg;
    logic [dbbsd_pkg::OUT_DATA_W-1:0]         out_data_reg;
    dbbsd_pkg::event_kind_t                   out_kind_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_range_reg <= dbbsd_pkg::HALF_RANGE_RESET;
        end else if (cfg_we) begin
            half_range_reg <= cfg_wdata;
        end
    end

    // input register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // byte classification in the command phase
    assign is_button = (phase_reg == dbbsd_pkg::PH_CMD)
                    && (in_byte_reg >= dbbsd_pkg::BTN_CODE_FIRST);
    assign is_start  = (phase_reg == dbbsd_pkg::PH_CMD)
                    && (in_byte_reg[7:3] == dbbsd_pkg::DIAL_START_HIGH)
                    && ({1'b0, in_byte_reg[2:0]} < 4'(dbbsd_pkg::DIAL_COUNT));
    assign resync    = (phase_reg == dbbsd_pkg::PH_CMD) && !is_button && !is_start;

    always_comb begin
        phase_next     = phase_reg;
        pend_dial_next = pend_dial_reg;
        pend_high_next = pend_high_reg;
        kind_next      = dbbsd_pkg::EV_NONE;
        unique case (phase_reg)
            dbbsd_pkg::PH_HIGH: begin
                pend_high_next = in_byte_reg;
                phase_next     = dbbsd_pkg::PH_LOW;
            end
            dbbsd_pkg::PH_LOW: begin
                phase_next = dbbsd_pkg::PH_CMD;
                kind_next  = dbbsd_pkg::EV_DIAL;
            end
            default: begin
                if (is_button) begin
                    kind_next = dbbsd_pkg::EV_BUTTON;
                end else if (is_start) begin
                    pend_dial_next = in_byte_reg[dbbsd_pkg::DIAL_IW-1:0];
                    phase_next     = dbbsd_pkg::PH_HIGH;
                end else begin
                    pend_dial_next = '0;
                    pend_high_next = '0;
                    kind_next      = dbbsd_pkg::EV_RESYNC;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dbbsd_pkg::PH_CMD;
            pend_dial_reg <= '0;
            pend_high_reg <= '0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            pend_dial_reg <= pend_dial_next;
            pend_high_reg <= pend_high_next;
        end
    end

    assign btn_cmd.commit = advance;
    assign btn_cmd.hit    = is_button;
    assign btn_cmd.clear  = resync;

    assign dial_cmd.commit = advance && (phase_reg == dbbsd_pkg::PH_LOW);
    assign dial_cmd.clear  = advance && resync;
    assign dial_cmd.index  = pend_dial_reg;

    dbbsd_button u_button (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (btn_cmd),
        .code        (in_byte_reg),
        .index       (btn_index),
        .pressed     (btn_pressed),
        .vector_next (btn_vector)
    );

    dbbsd_dial u_dial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (dial_cmd),
        .position   (signed'({pend_high_reg, in_byte_reg})),
        .half_range (half_range_reg),
        .offset     (dial_offset),
        .saturated  (dial_sat),
        .delta      (dial_delta)
    );

    // zero the fields that do not belong to this event
    always_comb begin
        data_next         = '0;
        data_next[37:6]   = btn_vector;
        if (kind_next == dbbsd_pkg::EV_BUTTON) begin
            data_next[4:0] = btn_index;
            data_next[5]   = btn_pressed;
        end
        if (kind_next == dbbsd_pkg::EV_DIAL) begin
            data_next[40:38] = pend_dial_reg;
            data_next[55:41] = dial_offset;
            data_next[56]    = dial_sat;
            data_next[73:57] = dial_delta;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= data_next;
            out_kind_reg <= kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule
